// ----- src/piecewise_polynomial_evaluator_top_macros.svh -----
// Assertion macros for the piecewise polynomial evaluator.
// Used by ppe_horner and the top level; expects clk and rst_n in scope.
`ifndef PIECEWISE_POLYNOMIAL_EVALUATOR_TOP_MACROS_SVH
`define PIECEWISE_POLYNOMIAL_EVALUATOR_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define PPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ppe_pkg.sv -----
// Shared types and constants of the piecewise polynomial evaluator.
// No dependencies; imported by every module of the block but ppe_ram.
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

  localparam int APB_AW = 4;   // three 32-bit registers at 0x0, 0x4, 0x8
  localparam int XW     = 33;  // argument, holds |x| up to 2^31
  localparam int CW     = 34;  // bound +/- tolerance compares
  localparam int YW     = 48;  // Q32.16 result

  localparam logic signed [YW-1:0] Y_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [YW-1:0] Y_MIN = 48'sh8000_0000_0000;
  localparam logic [63:0] POS_LIMIT = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_8000_0000_0000;

  typedef enum logic {
    OP_EVAL = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_TOLERANCE = 2'd0,
    REG_USE_ABS   = 2'd1,
    REG_SEG_COUNT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] tolerance;
    logic        use_absolute;
    logic [4:0]  segment_count;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic [3:0]         segment_index;
    logic signed [31:0] seg_lower;
    logic signed [31:0] seg_upper;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] coef_e;
    logic [1:0]         seg_degree;
    logic signed [31:0] x_value;
  } in_item_t;

  typedef struct packed {
    logic signed [YW-1:0] y_value;
    logic                 out_of_bounds;
    logic [3:0]           segment_used;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR_CHK,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_FETCH_RD,
    S_FETCH_WAIT,
    S_EVAL,
    S_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_ABS,
    H_MUL_LO,
    H_MUL_HI,
    H_SUM,
    H_SAT,
    H_ADD
  } hrn_state_t;

endpackage

`default_nettype wire

// ----- src/ppe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/ppe_cfg_regs.sv -----
// APB-style configuration registers: tolerance, absolute-value enable, segment count.
// Depends on ppe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppe_cfg_regs
  import ppe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [30:0] tol_r, tol_nxt;
  logic        use_abs_r, use_abs_nxt;
  logic [4:0]  seg_cnt_r, seg_cnt_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r     <= '0;
      use_abs_r <= 1'b0;
      seg_cnt_r <= 5'd1;
    end else begin
      tol_r     <= tol_nxt;
      use_abs_r <= use_abs_nxt;
      seg_cnt_r <= seg_cnt_nxt;
    end
  end

  always_comb begin
    tol_nxt     = tol_r;
    use_abs_nxt = use_abs_r;
    seg_cnt_nxt = seg_cnt_r;
    prdata      = '0;
    case (paddr[3:2])
      REG_TOLERANCE: begin
        prdata = {1'b0, tol_r};
        if (wr_en) tol_nxt = pwdata[30:0];
      end
      REG_USE_ABS: begin
        prdata = {31'b0, use_abs_r};
        if (wr_en) use_abs_nxt = pwdata[0];
      end
      REG_SEG_COUNT: begin
        prdata = {27'b0, seg_cnt_r};
        if (wr_en) seg_cnt_nxt = pwdata[4:0];
      end
      default: prdata = '0;
    endcase
  end

  assign cfg.tolerance     = tol_r;
  assign cfg.use_absolute  = use_abs_r;
  assign cfg.segment_count = seg_cnt_r;

endmodule

`default_nettype wire

// ----- src/ppe_horner.sv -----
// Shared Horner unit: one 24x32 multiplier reused over six steps per coefficient.
// Depends on ppe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_polynomial_evaluator_top_macros.svh"

module ppe_horner
  import ppe_pkg::*;
#(
  parameter int IN_W = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic signed [XW-1:0]   x_val,
  input  wire logic [1:0]             degree,
  input  wire logic signed [IN_W-1:0] coef [5],
  output logic                        done,
  output logic signed [YW-1:0]        y_val
);

  hrn_state_t state_r, state_nxt;
  logic       done_r, done_nxt;

  logic signed [YW-1:0] acc_r, acc_nxt;
  logic [YW-1:0]        mag_r, mag_nxt;
  logic [31:0]          mx_r, mx_nxt;
  logic                 xneg_r, xneg_nxt;
  logic [55:0]          prod_r, prod_nxt;
  logic [63:0]          m_r, m_nxt;
  logic signed [YW-1:0] q_r, q_nxt;
  logic [2:0]           k_r, k_nxt;
  logic [1:0]           deg_r, deg_nxt;

  logic [23:0]          mul_a;
  logic [55:0]          prod;
  logic                 neg;
  logic signed [YW:0]   sum;
  logic signed [IN_W-1:0] coef_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    mag_r  <= mag_nxt;
    mx_r   <= mx_nxt;
    xneg_r <= xneg_nxt;
    prod_r <= prod_nxt;
    m_r    <= m_nxt;
    q_r    <= q_nxt;
    k_r    <= k_nxt;
    deg_r  <= deg_nxt;
  end

  // the shared multiplier: low then high 24 bits of |acc| times |x|
  assign mul_a  = (state_r == H_MUL_HI) ? mag_r[47:24] : mag_r[23:0];
  assign prod   = 56'(mul_a) * 56'(mx_r);
  assign neg    = acc_r[YW-1] ^ xneg_r;
  assign coef_k = coef[k_r];
  assign sum    = (YW+1)'(q_r) + (YW+1)'(coef_k);

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    acc_nxt   = acc_r;
    mag_nxt   = mag_r;
    mx_nxt    = mx_r;
    xneg_nxt  = xneg_r;
    prod_nxt  = prod_r;
    m_nxt     = m_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    deg_nxt   = deg_r;
    case (state_r)
      H_IDLE: begin
        if (start) begin
          acc_nxt   = YW'(coef[0]);
          mx_nxt    = x_val[XW-1] ? 32'(-x_val) : x_val[31:0];
          xneg_nxt  = x_val[XW-1];
          k_nxt     = 3'd1;
          deg_nxt   = degree;
          state_nxt = H_ABS;
        end
      end
      H_ABS: begin
        mag_nxt   = acc_r[YW-1] ? YW'(-acc_r) : acc_r;
        state_nxt = H_MUL_LO;
      end
      H_MUL_LO: begin
        prod_nxt  = prod;
        state_nxt = H_MUL_HI;
      end
      H_MUL_HI: begin
        m_nxt     = 64'(prod_r >> 16);
        prod_nxt  = prod;
        state_nxt = H_SUM;
      end
      H_SUM: begin
        m_nxt     = m_r + {prod_r, 8'b0};
        state_nxt = H_SAT;
      end
      H_SAT: begin
        if (!neg) begin
          q_nxt = (m_r > POS_LIMIT) ? Y_MAX : m_r[YW-1:0];
        end else begin
          q_nxt = (m_r > NEG_LIMIT) ? Y_MIN : YW'(-m_r[YW-1:0]);
        end
        state_nxt = H_ADD;
      end
      H_ADD: begin
        if (sum > (YW+1)'(Y_MAX)) begin
          acc_nxt = Y_MAX;
        end else if (sum < (YW+1)'(Y_MIN)) begin
          acc_nxt = Y_MIN;
        end else begin
          acc_nxt = sum[YW-1:0];
        end
        if (k_r == 3'(deg_r) + 3'd1) begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = H_ABS;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  assign done  = done_r;
  assign y_val = acc_r;

  `PPE_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "horner done held over two cycles")
  `PPE_ASSERT_IMP(a_start_idle, start, state_r == H_IDLE, "horner started while busy")
  `PPE_ASSERT_IMP(a_step_range, state_r != H_IDLE,
                  (k_r != 3'd0) && (k_r <= 3'(deg_r) + 3'd1),
                  "horner coefficient step out of range")

endmodule

`default_nettype wire

// ----- src/piecewise_polynomial_evaluator_top.sv -----
// Piecewise polynomial evaluator, top level: segment table, search sequencer,
// output register. Depends on ppe_pkg, ppe_ram, ppe_cfg_regs, ppe_horner, macro header.
//
// Usage:
//   in_valid/in_ready/in_data carry requests. A load request (operation = 1) writes
//   one segment into the table in the cycle it is accepted and returns nothing.
//   An evaluate request (operation = 0) returns one result on out_valid/out_ready/
//   out_data: the saturated Q32.16 value, the clamp flag and the segment used.
//   Registers sit on the APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready)
//   and must be written only while the block is idle; the block does not enforce it.
//   One evaluate request at a time. No search runs when the cached segment holds x;
//   otherwise the search may visit the segments in order, up to the effective
//   segment count. The table sits in a single-port-read RAM, read one entry at a time
//   with a check after each read, and the Horner steps share one 24x32 multiplier.
//   in_ready is high in the idle state; a finished result waits in the output
//   register while the next request is taken. If out_ready stays low, the next
//   evaluation completes and then holds until the register frees.
//   Reset clears the sequencer, the output valid, the cached segment (to 0) and the
//   registers (tolerance 0, absolute off, count 1). The table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_polynomial_evaluator_top_macros.svh"

module piecewise_polynomial_evaluator_top
  import ppe_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16,
  parameter int VALUE_WIDTH  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int IN_W    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int ENTRY_W = 7 * IN_W + 2;
  localparam int IDX_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);

  cfg_t cfg;

  top_state_t           state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [IDX_W-1:0]     sel_r, sel_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic signed [XW-1:0] x_r, x_nxt;
  logic                 oob_r, oob_nxt;
  logic signed [CW-1:0] lower0_r, lower0_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       last;
  logic                   idx_ok;
  logic signed [IN_W-1:0] x_raw;
  logic signed [XW-1:0]   x_ext;
  logic signed [XW-1:0]   x_in;
  logic signed [IN_W-1:0] e_lo_raw;
  logic signed [IN_W-1:0] e_up_raw;
  logic signed [IN_W-1:0] e_coef [5];
  logic [1:0]             e_degree;
  logic signed [CW-1:0]   e_lower;
  logic signed [CW-1:0]   e_upper;
  logic signed [CW-1:0]   x_cmp;
  logic signed [CW-1:0]   tol_ext;
  logic signed [CW-1:0]   lo_t;
  logic signed [CW-1:0]   hi_t;
  logic signed [CW-1:0]   lo0;
  logic                   cur_ok;
  logic                   hrn_start;
  logic                   hrn_done;
  logic signed [YW-1:0]   hrn_y;

  ppe_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_data.segment_index)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppe_horner #(
    .IN_W (IN_W)
  ) u_horner (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hrn_start),
    .x_val  (x_r),
    .degree (e_degree),
    .coef   (e_coef),
    .done   (hrn_done),
    .y_val  (hrn_y)
  );

  // table entry: lower, upper, a..e, degree from the low end up
  always_comb begin
    ram_wdata                    = '0;
    ram_wdata[0 +: IN_W]         = in_data.seg_lower[IN_W-1:0];
    ram_wdata[IN_W +: IN_W]      = in_data.seg_upper[IN_W-1:0];
    ram_wdata[2*IN_W +: IN_W]    = in_data.coef_a[IN_W-1:0];
    ram_wdata[3*IN_W +: IN_W]    = in_data.coef_b[IN_W-1:0];
    ram_wdata[4*IN_W +: IN_W]    = in_data.coef_c[IN_W-1:0];
    ram_wdata[5*IN_W +: IN_W]    = in_data.coef_d[IN_W-1:0];
    ram_wdata[6*IN_W +: IN_W]    = in_data.coef_e[IN_W-1:0];
    ram_wdata[7*IN_W +: 2]       = in_data.seg_degree;
  end

  always_comb begin
    e_lo_raw = ram_rdata[0 +: IN_W];
    e_up_raw = ram_rdata[IN_W +: IN_W];
    for (int k = 0; k < 5; k++) begin
      e_coef[k] = ram_rdata[(2 + k) * IN_W +: IN_W];
    end
    e_degree = ram_rdata[7*IN_W +: 2];
  end

  assign e_lower = CW'(e_lo_raw);
  assign e_upper = CW'(e_up_raw);
  assign x_cmp   = CW'(x_r);
  assign tol_ext = {3'b000, cfg.tolerance};
  assign lo_t    = e_lower - tol_ext;
  assign hi_t    = e_upper + tol_ext;
  assign lo0     = (idx_r == '0) ? e_lower : lower0_r;

  // effective count: zero reads as one, above the table size saturates
  always_comb begin
    if (cfg.segment_count == 5'd0) begin
      count = CNT_W'(1);
    end else if (32'(cfg.segment_count) > 32'(MAX_SEGMENTS)) begin
      count = CNT_W'(MAX_SEGMENTS);
    end else begin
      count = CNT_W'(cfg.segment_count);
    end
  end

  assign last   = IDX_W'(count - CNT_W'(1));
  assign cur_ok = CNT_W'(cur_r) < count;
  assign idx_ok = {28'b0, in_data.segment_index} < 32'(MAX_SEGMENTS);

  assign x_raw = in_data.x_value[IN_W-1:0];
  assign x_ext = XW'(x_raw);
  assign x_in  = (cfg.use_absolute && x_ext[XW-1]) ? -x_ext : x_ext;

  assign in_ready = (state_r == S_IDLE);
  assign ram_we   = in_valid && in_ready && (in_data.operation == OP_LOAD) && idx_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    sel_r      <= sel_nxt;
    idx_r      <= idx_nxt;
    x_r        <= x_nxt;
    oob_r      <= oob_nxt;
    lower0_r   <= lower0_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cur_nxt       = cur_r;
    sel_nxt       = sel_r;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    oob_nxt       = oob_r;
    lower0_nxt    = lower0_r;
    ram_raddr     = sel_r;
    hrn_start     = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        ram_raddr = cur_r;
        if (in_valid && (in_data.operation == OP_EVAL)) begin
          x_nxt     = x_in;
          oob_nxt   = 1'b0;
          state_nxt = S_CUR_CHK;
        end
      end
      S_CUR_CHK: begin
        sel_nxt   = cur_r;
        state_nxt = S_FETCH_RD;
        if (cur_ok && (cur_r == '0) && (x_cmp < e_lower)) begin
          x_nxt   = XW'(e_lower);
          oob_nxt = 1'b1;
        end else if (cur_ok && (cur_r == last) && (x_cmp > e_upper)) begin
          x_nxt   = XW'(e_upper);
          oob_nxt = 1'b1;
        end else if (!cur_ok || (x_cmp < e_lower) || (x_cmp > e_upper)) begin
          idx_nxt   = '0;
          state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        ram_raddr = idx_r;
        state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (idx_r == '0) lower0_nxt = e_lower;
        if ((lo_t <= x_cmp) && (x_cmp <= hi_t)) begin
          sel_nxt   = idx_r;
          state_nxt = S_FETCH_RD;
        end else if (idx_r == last) begin
          // no match: x at or below the first lower bound clamps there, else to the last upper
          oob_nxt   = 1'b1;
          state_nxt = S_FETCH_RD;
          if (x_cmp <= lo0) begin
            sel_nxt = '0;
            x_nxt   = XW'(lo0);
          end else begin
            sel_nxt = last;
            x_nxt   = XW'(e_upper);
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_FETCH_RD: begin
        state_nxt = S_FETCH_WAIT;
      end
      S_FETCH_WAIT: begin
        hrn_start = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (hrn_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.y_value       = hrn_y;
          out_data_nxt.out_of_bounds = oob_r;
          out_data_nxt.segment_used  = 4'(sel_r);
          cur_nxt                    = sel_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PPE_ASSERT_NEXT(a_done_to_out, (state_r == S_DONE) && (!out_valid_r || out_ready),
                   out_valid_r && (state_r == S_IDLE), "finished result not registered")
  `PPE_ASSERT_IMP(a_search_range, state_r == S_SRCH_CHK, CNT_W'(idx_r) < count,
                  "search index beyond segment count")
  `PPE_ASSERT_NEXT(a_load_no_eval,
                   in_valid && in_ready && (in_data.operation == OP_LOAD),
                   state_r == S_IDLE, "load request started an evaluation")
  `PPE_ASSERT_IMP(a_horner_done_eval, hrn_done, state_r == S_EVAL,
                  "horner finished outside evaluation")

endmodule

`default_nettype wire

// ----- tb/sv/ppe_eval_check.sv -----
// Result checker for the piecewise polynomial evaluator: mirrors the segment table,
// the registers and the cached segment, predicts each evaluate result and compares.
// Depends on ppe_pkg; watches the request, result and APB channels of the block.
`timescale 1ns / 1ps

module ppe_eval_check
  import ppe_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int unsigned       pending,
  output int unsigned       mismatches
);

  longint             seg_lo   [MAX_SEGMENTS];
  longint             seg_hi   [MAX_SEGMENTS];
  logic signed [31:0] seg_coef [MAX_SEGMENTS][5];
  logic [1:0]         seg_deg  [MAX_SEGMENTS];

  int unsigned cached_seg;
  logic [30:0] tol_q;
  logic        abs_en;
  logic [4:0]  seg_count;

  out_item_t   awaited_evals[$];
  out_item_t   want;
  int unsigned load_idx;
  int unsigned bad_count = 0;
  int unsigned queued = 0;

  assign mismatches = bad_count;
  assign pending    = queued;

  function automatic logic signed [95:0] sat_q32_16(logic signed [95:0] v);
    if (v > Y_MAX) return Y_MAX;
    if (v < Y_MIN) return Y_MIN;
    return v;
  endfunction

  // Horner in Q16.16 x, Q32.16 accumulator; truncating product, saturate every step
  function automatic logic signed [47:0] horner_value(int unsigned s, longint x);
    logic signed [95:0] acc, prod, q;
    acc = seg_coef[s][0];
    for (int k = 1; k <= seg_deg[s] + 1; k++) begin
      prod = acc * x;
      q = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);
      acc = sat_q32_16(sat_q32_16(q) + seg_coef[s][k]);
    end
    return acc[47:0];
  endfunction

  function automatic out_item_t evaluate_point(logic signed [31:0] x_raw);
    int unsigned n_act, last, cur;
    longint      x, tol;
    bit          clamped, found;
    out_item_t   r;
    n_act = (seg_count == 0) ? 1 : ((seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count);
    last = n_act - 1;
    cur = cached_seg;
    tol = longint'(tol_q);
    x = longint'(x_raw);
    clamped = 1'b0;
    found = 1'b0;
    if (abs_en && x < 0) x = -x;

    if (cur < n_act && cur == 0 && x < seg_lo[0]) begin
      x = seg_lo[0];
      clamped = 1'b1;
    end else if (cur < n_act && cur == last && x > seg_hi[last]) begin
      x = seg_hi[last];
      clamped = 1'b1;
    end else if (cur >= n_act || x < seg_lo[cur] || x > seg_hi[cur]) begin
      for (int i = 0; i < n_act; i++) begin
        if (!found && seg_lo[i] - tol <= x && x <= seg_hi[i] + tol) begin
          cur = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        clamped = 1'b1;
        if (x <= seg_lo[0]) begin
          cur = 0;
          x = seg_lo[0];
        end else begin
          cur = last;
          x = seg_hi[last];
        end
      end
    end

    cached_seg = cur;
    r.y_value = horner_value(cur, x);
    r.out_of_bounds = clamped;
    r.segment_used = cur[3:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cached_seg = 0;
      tol_q = '0;
      abs_en = 1'b0;
      seg_count = 5'd1;
      awaited_evals.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_TOLERANCE: tol_q = pwdata[30:0];
          REG_USE_ABS:   abs_en = pwdata[0];
          REG_SEG_COUNT: seg_count = pwdata[4:0];
          default: ;
        endcase
      end

      // results first: a result never belongs to a request taken at the same edge
      if (out_valid && out_ready) begin
        if (awaited_evals.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected result y=%h oob=%b seg=%0d", $time,
                     out_data.y_value, out_data.out_of_bounds, out_data.segment_used);
        end else begin
          want = awaited_evals.pop_front();
          if (out_data.y_value !== want.y_value ||
              out_data.out_of_bounds !== want.out_of_bounds ||
              out_data.segment_used !== want.segment_used) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: mismatch y exp %h got %h, oob exp %b got %b, seg exp %0d got %0d",
                       $time, want.y_value, out_data.y_value, want.out_of_bounds,
                       out_data.out_of_bounds, want.segment_used, out_data.segment_used);
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_data.operation == OP_LOAD) begin
          load_idx = in_data.segment_index;
          seg_lo[load_idx] = in_data.seg_lower;
          seg_hi[load_idx] = in_data.seg_upper;
          seg_coef[load_idx][0] = in_data.coef_a;
          seg_coef[load_idx][1] = in_data.coef_b;
          seg_coef[load_idx][2] = in_data.coef_c;
          seg_coef[load_idx][3] = in_data.coef_d;
          seg_coef[load_idx][4] = in_data.coef_e;
          seg_deg[load_idx] = in_data.seg_degree;
        end else begin
          awaited_evals.insert(awaited_evals.size(), evaluate_point(in_data.x_value));
        end
      end
    end
    queued <= awaited_evals.size();
  end

endmodule

// ----- tb/sv/piecewise_polynomial_evaluator_top_tb.sv -----
// Testbench top for the piecewise polynomial evaluator: clock, reset, request and
// result traffic with random idling, register programming, watchdog and verdict.
// Depends on ppe_pkg, the block's RTL and ppe_eval_check.
`timescale 1ns / 1ps

module piecewise_polynomial_evaluator_top_tb;
  import ppe_pkg::*;

  localparam int     MAX_SEG       = 16;
  localparam int     ITEM_TARGET   = 1000;
  localparam int     PHASE_LEN     = 60;
  localparam int     SETTLE_CYCLES = 80;    // a bit above the worst evaluate latency
  localparam int     STALL_LIMIT   = 4000;
  localparam int     HOLD_CYCLES   = 400;
  localparam longint Q_MAX         = 64'sd2147483647;
  localparam longint Q_MIN         = -64'sd2147483648;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int unsigned       pending;
  int unsigned       mismatches;

  // current segment layout, used to aim x at and around segments
  longint      lay_lo [MAX_SEG];
  longint      lay_hi [MAX_SEG];
  int          lay_n;
  longint      last_x;
  logic [30:0] cur_tol;
  int          items_sent;
  bit          send_quiet;

  piecewise_polynomial_evaluator_top DUT (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ppe_eval_check #(.MAX_SEGMENTS(MAX_SEG)) eval_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .pending, .mismatches
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint pick_between(longint a, longint b);
    longint unsigned span, r;
    if (b <= a) return a;
    span = b - a;
    span = span + 1;
    r = {$urandom, $urandom};
    return a + longint'(r % span);
  endfunction

  function automatic longint to_q16(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_coef();
    int cls;
    cls = $urandom_range(0, 19);
    if (cls < 11) return 32'(pick_between(-(1 << 17), 1 << 17));
    if (cls < 16) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [30:0] pick_tol();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3, 4: return 31'($urandom_range(0, 4096));
      5, 6, 7: return 31'($urandom_range(0, 1048576));
      8: return 31'($urandom);
      default: return 31'h7FFF_FFFF;
    endcase
  endfunction

  function automatic in_item_t random_bits();
    in_item_t r;
    r.operation = 1'($urandom);
    r.segment_index = 4'($urandom);
    r.seg_lower = $urandom;
    r.seg_upper = $urandom;
    r.coef_a = $urandom;
    r.coef_b = $urandom;
    r.coef_c = $urandom;
    r.coef_d = $urandom;
    r.coef_e = $urandom;
    r.seg_degree = 2'($urandom);
    r.x_value = $urandom;
    return r;
  endfunction

  function automatic in_item_t make_load(int idx, longint lo, longint hi);
    in_item_t r;
    r = random_bits();
    r.operation = OP_LOAD;
    r.segment_index = 4'(idx);
    r.seg_lower = 32'(lo);
    r.seg_upper = 32'(hi);
    r.coef_a = pick_coef();
    r.coef_b = pick_coef();
    r.coef_c = pick_coef();
    r.coef_d = pick_coef();
    r.coef_e = pick_coef();
    r.seg_degree = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic in_item_t make_eval(longint x);
    in_item_t r;
    r = random_bits();
    r.operation = OP_EVAL;
    r.x_value = 32'(x);
    return r;
  endfunction

  task automatic push_request(in_item_t req);
    int gap;
    gap = (!send_quiet && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (items_sent % 97 == 0) send_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // block is idle once every evaluate has returned and the settle time has passed
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup then access; psel stays up across back-to-back writes
  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [30:0] tol, logic abs_on, logic [4:0] cnt);
    wait_quiet();
    apb_write(REG_TOLERANCE, {1'b0, tol});
    apb_write(REG_USE_ABS, {31'b0, abs_on});
    apb_write(REG_SEG_COUNT, {27'b0, cnt});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_tol = tol;
    lay_n = (cnt == 0) ? 1 : ((cnt > MAX_SEG) ? MAX_SEG : cnt);
  endtask

  // ascending segments with random width, some gaps and overlaps
  task automatic build_layout(int n);
    longint w, base, lo, hi, q;
    int     cls;
    cls = $urandom_range(0, 9);
    if (cls < 4) w = pick_between(256, 16384);
    else if (cls < 8) w = pick_between(16384, 4194304);
    else w = pick_between(4194304, 64'sd4294967295 / n);
    base = pick_between(Q_MIN, Q_MAX - n * w + 1);
    for (int i = 0; i < n; i++) begin
      lo = base + i * w;
      hi = lo + w - 1;
      q = w / 4;
      case ($urandom_range(0, 9))
        6, 7: hi -= pick_between(0, q);
        8: hi += pick_between(0, q);
        9: lo += pick_between(0, q);
        default: ;
      endcase
      lo = to_q16(lo);
      hi = to_q16(hi);
      lay_lo[i] = lo;
      lay_hi[i] = hi;
      push_request(make_load(i, lo, hi));
    end
  endtask

  task automatic random_request();
    in_item_t req;
    longint   x, slack;
    int       j, pick;
    req = random_bits();
    j = $urandom_range(0, lay_n - 1);
    pick = $urandom_range(0, 99);
    if (pick < 9) begin
      // new coefficients for a segment in use, bounds kept
      req = make_load(j, lay_lo[j], lay_hi[j]);
    end else if (pick < 12) begin
      req.operation = OP_LOAD;
    end else begin
      req.operation = OP_EVAL;
      slack = (longint'(cur_tol) > 1048576) ? 1048576 : longint'(cur_tol);
      slack += 64;
      if (pick < 62)
        x = pick_between(lay_lo[j], lay_hi[j]);
      else if (pick < 76)
        x = (($urandom_range(0, 1) == 0) ? lay_lo[j] : lay_hi[j]) + pick_between(-slack, slack);
      else if (pick < 84)
        x = last_x;
      else if (pick < 92)
        x = ($urandom_range(0, 1) == 0) ? lay_lo[0] - pick_between(1, 1 << 20)
                                        : lay_hi[lay_n - 1] + pick_between(1, 1 << 20);
      else
        x = longint'(req.x_value);
      x = to_q16(x);
      req.x_value = 32'(x);
      last_x = x;
    end
    push_request(req);
  endtask

  // result side: random stalls, quiet stretches and long hold-offs
  initial begin
    int gap, drained, mode_left, hold_at;
    bit quiet;
    out_ready = 1'b0;
    gap = 0;
    drained = 0;
    mode_left = 0;
    hold_at = 150;
    quiet = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) drained++;
      if (mode_left == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (drained >= hold_at) begin
        hold_at += 350;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) gap = idle_len();
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_item_t    req;
    logic [31:0] fill;
    int          phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_sent = 0;
    send_quiet = 1'b0;
    last_x = 0;
    cur_tol = '0;
    lay_n = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // every table entry gets loaded so no evaluate ever touches an unwritten one
    program_regs(31'd0, 1'b0, 5'd16);
    for (int i = 0; i < MAX_SEG; i++) begin
      lay_lo[i] = (i == 0) ? Q_MIN : longint'(i - 8) <<< 20;
      lay_hi[i] = (i == MAX_SEG - 1) ? Q_MAX : (longint'(i - 7) <<< 20) - 1;
      req = make_load(i, lay_lo[i], lay_hi[i]);
      // outer segments carry extreme coefficients to drive saturation
      if (i == 0 || i == MAX_SEG - 1) begin
        fill = (i == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        req.coef_a = fill;
        req.coef_b = fill;
        req.coef_c = fill;
        req.coef_d = fill;
        req.coef_e = fill;
        req.seg_degree = 2'd3;
      end
      push_request(req);
    end
    push_request(make_eval(Q_MIN));
    push_request(make_eval(Q_MAX));
    push_request(make_eval(0));
    push_request(make_eval(1));
    push_request(make_eval(-1));
    push_request(make_eval(-(longint'(5) <<< 20) + 12345));

    // fewer segments: clamp at the last one, then search back to the first
    program_regs(31'd0, 1'b0, 5'd4);
    push_request(make_eval(Q_MAX));
    push_request(make_eval(Q_MIN));
    push_request(make_eval(Q_MIN));

    // |most negative x| exceeds every bound: search fails, clamp high
    program_regs(31'd0, 1'b1, 5'd16);
    push_request(make_eval(Q_MIN));
    push_request(make_eval(-1));

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: program_regs(31'd0, 1'b0, 5'd16);
        1: program_regs(31'h7FFF_FFFF, 1'b1, 5'd1);
        2: program_regs(31'd0, 1'b1, 5'd0);
        3: program_regs(pick_tol(), 1'b0, 5'd31);
        4: program_regs(31'd1, 1'b0, 5'd17);
        default:
          program_regs(pick_tol(), 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 16)));
      endcase
      build_layout(lay_n);
      repeat (PHASE_LEN) random_request();
      phase++;
    end

    wait_quiet();
    if (mismatches == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/ppe_pkg.sv
src/ppe_ram.sv
src/ppe_cfg_regs.sv
src/ppe_horner.sv
src/piecewise_polynomial_evaluator_top.sv
tb/sv/ppe_eval_check.sv
tb/sv/piecewise_polynomial_evaluator_top_tb.sv
